// ----- design/vfof_pkg.sv -----
// shared constants and types of the vector field orientation flip block
package vfof_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 16;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEPTH  = 2'd2;

  // register field widths
  localparam int unsigned GEO_BITS   = 9;
  localparam int unsigned DEPTH_BITS = 16;

  // input kind codes
  localparam logic KIND_VOXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // window tap order
  localparam int unsigned TAP_CUR  = 0;
  localparam int unsigned TAP_CUR1 = 1;
  localparam int unsigned TAP_LN   = 2;
  localparam int unsigned TAP_LN1  = 3;
  localparam int unsigned TAP_PL   = 4;
  localparam int unsigned TAP_PL1  = 5;
  localparam int unsigned TAP_PN   = 6;
  localparam int unsigned TAP_CTR  = 7;
  localparam int unsigned NUM_TAPS = 8;

  // bounds and end flags of the voxel under evaluation
  typedef struct packed {
    logic x_in;
    logic y_in;
    logic z_in;
    logic last;
  } vfof_meta_t;

endpackage

// ----- design/vfof_if.sv -----
// channel interfaces of the vector field orientation flip block

interface vfof_in_if #(parameter int COMP_BITS = 16);
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [COMP_BITS-1:0] in_x;
  logic [COMP_BITS-1:0] in_y;
  logic [COMP_BITS-1:0] in_z;
  logic                 in_mask;
  modport source (output valid, kind, in_x, in_y, in_z, in_mask, input ready);
  modport sink (input valid, kind, in_x, in_y, in_z, in_mask, output ready);
endinterface

interface vfof_out_if #(parameter int COMP_BITS = 16);
  logic                 valid;
  logic                 ready;
  logic [COMP_BITS-1:0] out_x;
  logic [COMP_BITS-1:0] out_y;
  logic [COMP_BITS-1:0] out_z;
  logic                 out_flipped;
  logic                 out_last;
  modport source (output valid, out_x, out_y, out_z, out_flipped, out_last, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_flipped, out_last, output ready);
endinterface

interface vfof_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- design/vfof_delay.sv -----
// line and plane delay memories that build the 2x2x2 window taps
module vfof_delay import vfof_pkg::*; #(
  parameter int MW = 256,
  parameter int MH = 256,
  parameter int CW = 16,
  localparam int PD  = MW * MH + MW,
  localparam int PAW = $clog2(PD),
  localparam int NW  = $clog2(PD + 1),
  localparam int LAW = (MW > 1) ? $clog2(MW) : 1,
  localparam int WW  = $clog2(MW + 1),
  localparam int EW  = 3 * CW + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  logic          restart_i,
  input  logic [WW-1:0] w_i,
  input  logic [NW-1:0] n_i,
  input  logic [EW-1:0] wr_data_i,
  output logic [EW-1:0] taps_o [NUM_TAPS]
);

  logic [EW-1:0]  line_mem  [MW];
  logic [EW-1:0]  plane_mem [PD];
  logic [LAW-1:0] lptr_q, lptr_d;
  logic [PAW-1:0] pptr_q, pptr_d;
  logic [NW:0]    sum2;
  logic [PAW-1:0] paddr2;
  logic [EW-1:0]  cur_q, cur1_q, ln_q, ln1_q, pl_q, pl1_q, pn_q, ctr_q;

  // circular pointers: line wraps at width, plane at width*height+width
  always_comb begin
    lptr_d = (WW'(lptr_q) == w_i - WW'(1)) ? '0 : lptr_q + LAW'(1);
    pptr_d = (NW'(pptr_q) == n_i - NW'(1)) ? '0 : pptr_q + PAW'(1);
    sum2   = (NW+1)'(pptr_q) + (NW+1)'(w_i);
    if (sum2 >= (NW+1)'(n_i)) begin
      sum2 = sum2 - (NW+1)'(n_i);
    end
    paddr2 = PAW'(sum2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lptr_q <= '0;
      pptr_q <= '0;
    end else if (restart_i) begin
      lptr_q <= '0;
      pptr_q <= '0;
    end else if (shift_i) begin
      lptr_q <= lptr_d;
      pptr_q <= pptr_d;
    end
  end

  // read-first memories and the one-voxel tap registers
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      ln_q              <= line_mem[lptr_q];
      line_mem[lptr_q]  <= wr_data_i;
      pn_q              <= plane_mem[pptr_q];
      pl_q              <= plane_mem[paddr2];
      plane_mem[pptr_q] <= wr_data_i;
      cur_q             <= wr_data_i;
      cur1_q            <= cur_q;
      ln1_q             <= ln_q;
      pl1_q             <= pl_q;
      ctr_q             <= pn_q;
    end
  end

  assign taps_o[TAP_CUR]  = cur_q;
  assign taps_o[TAP_CUR1] = cur1_q;
  assign taps_o[TAP_LN]   = ln_q;
  assign taps_o[TAP_LN1]  = ln1_q;
  assign taps_o[TAP_PL]   = pl_q;
  assign taps_o[TAP_PL1]  = pl1_q;
  assign taps_o[TAP_PN]   = pn_q;
  assign taps_o[TAP_CTR]  = ctr_q;

endmodule

// ----- design/vfof_calc.sv -----
// neighbour sum, dot product and conditional negation pipeline
module vfof_calc import vfof_pkg::*; #(
  parameter int CW = 16,
  localparam int EW = 3 * CW + 1,
  localparam int SW = CW + 3,
  localparam int PW = SW + CW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          a_valid_i,
  input  vfof_meta_t    a_meta_i,
  input  logic [EW-1:0] taps_i [NUM_TAPS],
  output logic          en_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [CW-1:0] out_x_o,
  output logic [CW-1:0] out_y_o,
  output logic [CW-1:0] out_z_o,
  output logic          out_flipped_o,
  output logic          out_last_o
);

  logic                 b_valid_q, c_valid_q, out_valid_q;
  logic [6:0]           use_n;
  logic [SW-1:0]        sum_d [3];
  logic signed [SW-1:0] sum_q [3];
  logic [EW-1:0]        ctr_b_q, ctr_c_q;
  vfof_meta_t           meta_b_q, meta_c_q;
  logic signed [PW-1:0] prod_q [3];
  logic signed [PW+1:0] dot;
  logic [CW-1:0]        comp;
  logic [CW-1:0]        res_d [3];
  logic                 flip_d;
  logic [CW-1:0]        res_q [3];
  logic                 flip_q, last_q;

  // whole pipeline moves when the output register is free
  assign en_o = !out_valid_q || out_ready_i;

  // neighbours that are in bounds; the mask is checked in the sum
  always_comb begin
    use_n[0] = a_meta_i.x_in;
    use_n[1] = a_meta_i.y_in;
    use_n[2] = a_meta_i.x_in && a_meta_i.y_in;
    use_n[3] = a_meta_i.z_in;
    use_n[4] = a_meta_i.x_in && a_meta_i.z_in;
    use_n[5] = a_meta_i.y_in && a_meta_i.z_in;
    use_n[6] = a_meta_i.x_in && a_meta_i.y_in && a_meta_i.z_in;
  end

  // stage b: component sums of the seven forward neighbours
  always_comb begin
    logic [EW-1:0] nb [7];
    nb[0] = taps_i[TAP_PN];
    nb[1] = taps_i[TAP_PL1];
    nb[2] = taps_i[TAP_PL];
    nb[3] = taps_i[TAP_LN1];
    nb[4] = taps_i[TAP_LN];
    nb[5] = taps_i[TAP_CUR1];
    nb[6] = taps_i[TAP_CUR];
    for (int n = 0; n < 3; n++) begin
      sum_d[n] = '0;
      for (int t = 0; t < 7; t++) begin
        if (use_n[t] && nb[t][3*CW]) begin
          sum_d[n] = sum_d[n] + {{3{nb[t][n*CW+CW-1]}}, nb[t][n*CW +: CW]};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      for (int n = 0; n < 3; n++) begin
        sum_q[n] <= signed'(sum_d[n]);
      end
      ctr_b_q  <= taps_i[TAP_CTR];
      meta_b_q <= a_meta_i;
    end
  end

  // stage c: products with the centre vector
  always_ff @(posedge clk_i) begin
    if (en_o) begin
      for (int n = 0; n < 3; n++) begin
        prod_q[n] <= sum_q[n] * signed'(ctr_b_q[n*CW +: CW]);
      end
      ctr_c_q  <= ctr_b_q;
      meta_c_q <= meta_b_q;
    end
  end

  // stage d: sign of the dot product and saturating negation
  always_comb begin
    dot    = (PW+2)'(prod_q[0]) + (PW+2)'(prod_q[1]) + (PW+2)'(prod_q[2]);
    flip_d = ctr_c_q[3*CW] && dot[PW+1];
    for (int n = 0; n < 3; n++) begin
      comp = ctr_c_q[n*CW +: CW];
      if (!flip_d) begin
        res_d[n] = comp;
      end else if (comp == {1'b1, {(CW-1){1'b0}}}) begin
        res_d[n] = {1'b0, {(CW-1){1'b1}}};
      end else begin
        res_d[n] = -comp;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      for (int n = 0; n < 3; n++) begin
        res_q[n] <= res_d[n];
      end
      flip_q <= flip_d;
      last_q <= meta_c_q.last;
    end
  end

  // valid bits of the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_o) begin
      b_valid_q   <= a_valid_i;
      c_valid_q   <= b_valid_q;
      out_valid_q <= c_valid_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_x_o       = res_q[0];
  assign out_y_o       = res_q[1];
  assign out_z_o       = res_q[2];
  assign out_flipped_o = flip_q;
  assign out_last_o    = last_q;

endmodule

// ----- design/vector_field_orientation_flip_top.sv -----
// top level of the vector field orientation flip block
//
// Voxels enter on in_ch in raster order, x fastest, one request per voxel
// (kind voxel) or per flush (kind flush). Results leave on out_ch in the same
// order. The geometry registers width, height and depth are written on
// cfg_ch at indexes 0, 1 and 2; a write to any of them restarts the volume.
// A voxel's result is released by the request that arrives one plane plus
// one line plus one voxel later; after the last voxel, flush requests drain
// the remaining results. If the volume holds fewer voxels than that lag,
// the block first pads the delay line by itself over each missing
// position, with in_ch not ready.
// One request is taken per cycle unless out_ch stalls or padding is under
// way. A released voxel then passes the registered delay memory read,
// neighbour sum, products and dot product sign. The throughput is set by the
// single write port of each delay memory, written per voxel, drain and pad.
// Reset clears all counters and the pipeline; memory contents are not
// cleared. When out_ch stalls, the whole pipeline holds and in_ch drops
// ready until the output register is taken.
module vector_field_orientation_flip_top import vfof_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int COMP_BITS  = 16
) (
  input logic            clk_i,
  input logic            rst_ni,
  vfof_in_if.sink        in_ch,
  vfof_out_if.source     out_ch,
  vfof_cfg_if.sink       cfg_ch
);

  localparam int PD  = MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH;
  localparam int NW  = $clog2(PD + 1);
  localparam int LW  = $clog2(PD + 2);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int EW  = 3 * COMP_BITS + 1;
  localparam int RST_W = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
  localparam int RST_H = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

  logic [WW-1:0]         w_q, w_d;
  logic [HW-1:0]         h_q, h_d;
  logic [DEPTH_BITS-1:0] d_q, d_d;
  logic [NW-1:0]         n_q;
  logic [LW-1:0]         lag_q;
  logic [WW+HW-1:0]      wh_d;
  logic [31:0]           raw;
  logic                  cfg_acc;
  logic                  cfg_hit;

  logic [XW-1:0]         ix_q, ox_q;
  logic [YW-1:0]         iy_q, oy_q;
  logic [DEPTH_BITS-1:0] iz_q, oz_q;
  logic                  in_done_q;
  logic [LW-1:0]         lead_q;

  logic                  en, in_acc, is_wr, emit, shift, pad, restart;
  logic                  ix_end, iy_end, iz_end, ox_end, oy_end, oz_end, out_last;
  logic                  a_valid_q;
  vfof_meta_t            a_meta_q;
  logic [EW-1:0]         wr_data;
  logic [EW-1:0]         taps [NUM_TAPS];

  // configuration writes, with out of range geometry clamped
  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;
  assign cfg_hit      = cfg_acc && (cfg_ch.index == REG_WIDTH || cfg_ch.index == REG_HEIGHT
                                    || cfg_ch.index == REG_DEPTH);

  always_comb begin
    w_d = w_q;
    h_d = h_q;
    d_d = d_q;
    raw = 32'(cfg_ch.data[GEO_BITS-1:0]);
    if (cfg_acc) begin
      unique case (cfg_ch.index)
        REG_WIDTH: begin
          if (raw == 32'd0) w_d = WW'(1);
          else if (raw > 32'(MAX_WIDTH)) w_d = WW'(MAX_WIDTH);
          else w_d = WW'(raw);
        end
        REG_HEIGHT: begin
          if (raw == 32'd0) h_d = HW'(1);
          else if (raw > 32'(MAX_HEIGHT)) h_d = HW'(MAX_HEIGHT);
          else h_d = HW'(raw);
        end
        REG_DEPTH: begin
          d_d = (cfg_ch.data == '0) ? DEPTH_BITS'(1) : cfg_ch.data[DEPTH_BITS-1:0];
        end
        default: begin
          d_d = d_q;
        end
      endcase
    end
    wh_d = (WW+HW)'(w_d) * (WW+HW)'(h_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q   <= WW'(RST_W);
      h_q   <= HW'(RST_H);
      d_q   <= DEPTH_BITS'(1);
      n_q   <= NW'(RST_W * RST_H + RST_W);
      lag_q <= LW'(RST_W * RST_H + RST_W + 1);
    end else if (cfg_acc) begin
      w_q   <= w_d;
      h_q   <= h_d;
      d_q   <= d_d;
      n_q   <= NW'(wh_d) + NW'(w_d);
      lag_q <= LW'(wh_d) + LW'(w_d) + LW'(1);
    end
  end

  // request decode
  assign ix_end   = WW'(ix_q) == w_q - WW'(1);
  assign iy_end   = HW'(iy_q) == h_q - HW'(1);
  assign iz_end   = iz_q == d_q - DEPTH_BITS'(1);
  assign ox_end   = WW'(ox_q) == w_q - WW'(1);
  assign oy_end   = HW'(oy_q) == h_q - HW'(1);
  assign oz_end   = oz_q == d_q - DEPTH_BITS'(1);
  assign out_last = ox_end && oy_end && oz_end;

  assign pad          = in_done_q && lead_q != '0 && lead_q != lag_q && en;
  assign in_ch.ready  = en && !(in_done_q && lead_q != '0 && lead_q != lag_q);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign is_wr        = in_acc && in_ch.kind == KIND_VOXEL && !in_done_q;
  assign emit         = in_acc && (is_wr ? (lead_q == lag_q) : (in_done_q && lead_q != '0));
  assign shift        = is_wr || emit || pad;
  assign restart      = cfg_hit || (emit && out_last);
  assign wr_data      = is_wr ? {in_ch.in_mask, in_ch.in_z, in_ch.in_y, in_ch.in_x} : '0;

  // input and output position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ix_q      <= '0;
      iy_q      <= '0;
      iz_q      <= '0;
      ox_q      <= '0;
      oy_q      <= '0;
      oz_q      <= '0;
      in_done_q <= 1'b0;
      lead_q    <= '0;
    end else if (restart) begin
      ix_q      <= '0;
      iy_q      <= '0;
      iz_q      <= '0;
      ox_q      <= '0;
      oy_q      <= '0;
      oz_q      <= '0;
      in_done_q <= 1'b0;
      lead_q    <= '0;
    end else begin
      if (is_wr) begin
        ix_q <= ix_end ? '0 : ix_q + XW'(1);
        if (ix_end) begin
          iy_q <= iy_end ? '0 : iy_q + YW'(1);
          if (iy_end) begin
            iz_q <= iz_q + DEPTH_BITS'(1);
            if (iz_end) begin
              in_done_q <= 1'b1;
            end
          end
        end
      end
      if (emit) begin
        ox_q <= ox_end ? '0 : ox_q + XW'(1);
        if (ox_end) begin
          oy_q <= oy_end ? '0 : oy_q + YW'(1);
          if (oy_end) begin
            oz_q <= oz_q + DEPTH_BITS'(1);
          end
        end
      end
      if (shift && !emit) begin
        lead_q <= lead_q + LW'(1);
      end
    end
  end

  // window stage valid and bounds of the released voxel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      a_meta_q.x_in <= !ox_end;
      a_meta_q.y_in <= !oy_end;
      a_meta_q.z_in <= !oz_end;
      a_meta_q.last <= out_last;
    end
  end

  vfof_delay #(
    .MW (MAX_WIDTH),
    .MH (MAX_HEIGHT),
    .CW (COMP_BITS)
  ) u_delay (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .shift_i   (shift),
    .restart_i (restart),
    .w_i       (w_q),
    .n_i       (n_q),
    .wr_data_i (wr_data),
    .taps_o    (taps)
  );

  vfof_calc #(
    .CW (COMP_BITS)
  ) u_calc (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .a_valid_i     (a_valid_q),
    .a_meta_i      (a_meta_q),
    .taps_i        (taps),
    .en_o          (en),
    .out_valid_o   (out_ch.valid),
    .out_ready_i   (out_ch.ready),
    .out_x_o       (out_ch.out_x),
    .out_y_o       (out_ch.out_y),
    .out_z_o       (out_ch.out_z),
    .out_flipped_o (out_ch.out_flipped),
    .out_last_o    (out_ch.out_last)
  );

endmodule

// ----- verif/vector_field_orientation_flip_top_tb.sv -----
// self-checking testbench of the vector field orientation flip block
module vector_field_orientation_flip_top_tb import vfof_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W = 256;
  localparam int MAX_H = 256;
  localparam longint STORE_DEPTH = longint'(MAX_W) * MAX_H + MAX_W + 2;
  localparam int IDLE_LIMIT = 6000;
  localparam int RAND_VOXELS = 120;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic        kind;
    logic [15:0] vx;
    logic [15:0] vy;
    logic [15:0] vz;
    logic        mask;
  } voxel_req_t;

  typedef struct packed {
    logic [15:0] vx;
    logic [15:0] vy;
    logic [15:0] vz;
    logic        flipped;
    logic        last;
  } flip_res_t;

  typedef struct {
    logic signed [15:0] c [3];
    bit                 m;
  } field_cell_t;

  logic clk;
  logic rst_n;

  vfof_in_if  #(.COMP_BITS(16)) in_ch ();
  vfof_out_if #(.COMP_BITS(16)) out_ch ();
  vfof_cfg_if                   cfg_ch ();

  vector_field_orientation_flip_top #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H),
    .COMP_BITS (16)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  // pending requests and predicted results
  voxel_req_t  req_q[$];
  flip_res_t   flip_q[$];
  int          err_cnt;

  // predictor state
  field_cell_t vox_store [STORE_DEPTH];
  longint      rx_pos;
  longint      tx_pos;
  longint      geo_w_reg;
  longint      geo_h_reg;
  longint      geo_d_reg;

  // stimulus shaping
  bit          calm_phase;
  int          stall_req_cnt;
  int          stall_done_cnt;

  // clock and initial levels
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_VOXEL;
    in_ch.in_x = '0;
    in_ch.in_y = '0;
    in_ch.in_z = '0;
    in_ch.in_mask = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_WIDTH;
    cfg_ch.data = '0;
    forever #2 clk = ~clk;
  end

  function automatic longint eff_w();
    if (geo_w_reg == 0) return 1;
    return (geo_w_reg > MAX_W) ? MAX_W : geo_w_reg;
  endfunction

  function automatic longint eff_h();
    if (geo_h_reg == 0) return 1;
    return (geo_h_reg > MAX_H) ? MAX_H : geo_h_reg;
  endfunction

  function automatic longint eff_d();
    return (geo_d_reg == 0) ? 1 : geo_d_reg;
  endfunction

  function automatic logic signed [15:0] neg_clip(logic signed [15:0] v);
    if (v == -16'sd32768) return 16'sd32767;
    return -v;
  endfunction

  // orientation decision for the voxel at linear position q
  function automatic flip_res_t orient_voxel(longint q, longint total);
    longint w, h, d, px, py, pz, p;
    longint s [3];
    longint dot;
    logic signed [15:0] v [3];
    flip_res_t r;
    w = eff_w();
    h = eff_h();
    d = eff_d();
    px = q % w;
    py = (q / w) % h;
    pz = q / (w * h);
    for (int n = 0; n < 3; n++) begin
      v[n] = vox_store[q % STORE_DEPTH].c[n];
      s[n] = 0;
    end
    r.flipped = 1'b0;
    if (vox_store[q % STORE_DEPTH].m) begin
      for (int k = 0; k < 2; k++)
        for (int j = 0; j < 2; j++)
          for (int i = 0; i < 2; i++) begin
            if (i == 0 && j == 0 && k == 0) continue;
            if (px + i >= w || py + j >= h || pz + k >= d) continue;
            p = (q + i + j * w + k * w * h) % STORE_DEPTH;
            if (!vox_store[p].m) continue;
            for (int n = 0; n < 3; n++) s[n] += vox_store[p].c[n];
          end
      dot = s[0] * v[0] + s[1] * v[1] + s[2] * v[2];
      if (dot < 0) begin
        r.flipped = 1'b1;
        for (int n = 0; n < 3; n++) v[n] = neg_clip(v[n]);
      end
    end
    r.vx = v[0];
    r.vy = v[1];
    r.vz = v[2];
    r.last = (q == total - 1);
    return r;
  endfunction

  function automatic void release_next(longint total);
    flip_q.push_back(orient_voxel(tx_pos, total));
    tx_pos++;
    if (tx_pos >= total) begin
      tx_pos = 0;
      rx_pos = 0;
    end
  endfunction

  // queue one request and predict what it releases
  function automatic void push_req(logic kind, logic [15:0] x, logic [15:0] y,
                                   logic [15:0] z, logic m);
    voxel_req_t r;
    longint w, h, total, lag, a;
    r.kind = kind;
    r.vx = x;
    r.vy = y;
    r.vz = z;
    r.mask = m;
    req_q.push_back(r);
    w = eff_w();
    h = eff_h();
    total = w * h * eff_d();
    lag = w * h + w + 1;
    if (kind == KIND_VOXEL && rx_pos < total) begin
      a = rx_pos % STORE_DEPTH;
      vox_store[a].c[0] = x;
      vox_store[a].c[1] = y;
      vox_store[a].c[2] = z;
      vox_store[a].m = m;
      rx_pos++;
      if (rx_pos - 1 >= lag) release_next(total);
    end else if (rx_pos >= total && tx_pos < total) begin
      release_next(total);
    end
  endfunction

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 7)) - 16'd3;
      3: return 16'($urandom_range(0, 1023)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void push_rand_voxel();
    push_req(KIND_VOXEL, rand_comp(), rand_comp(), rand_comp(), $urandom_range(0, 3) != 0);
  endfunction

  // drain the open volume with flushes, sometimes a surplus voxel instead
  function automatic void drain_volume();
    while (rx_pos != 0) begin
      if ($urandom_range(0, 9) == 0) push_rand_voxel();
      else push_req(KIND_FLUSH, 16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    end
    repeat ($urandom_range(0, 2))
      push_req(KIND_FLUSH, 16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
  endfunction

  // one full volume with some early flushes mixed in
  function automatic int push_volume();
    longint total;
    total = eff_w() * eff_h() * eff_d();
    for (longint n = 0; n < total; n++) begin
      if ($urandom_range(0, 19) == 0)
        push_req(KIND_FLUSH, 16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
      push_rand_voxel();
    end
    drain_volume();
    return int'(total);
  endfunction

  task automatic wait_idle();
    while (req_q.size() != 0 || flip_q.size() != 0 || in_ch.valid) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_WIDTH:  geo_w_reg = val & 16'h01ff;
      REG_HEIGHT: geo_h_reg = val & 16'h01ff;
      REG_DEPTH:  geo_d_reg = val;
      default: ;
    endcase
    rx_pos = 0;
    tx_pos = 0;
    @(posedge clk);
  endtask

  task automatic set_geometry(logic [15:0] w, logic [15:0] h, logic [15:0] d);
    wait_idle();
    case ($urandom_range(0, 2))
      0: begin
        cfg_write(REG_WIDTH, w);
        cfg_write(REG_HEIGHT, h);
        cfg_write(REG_DEPTH, d);
      end
      1: begin
        cfg_write(REG_DEPTH, d);
        cfg_write(REG_WIDTH, w);
        cfg_write(REG_HEIGHT, h);
      end
      default: begin
        cfg_write(REG_HEIGHT, h);
        cfg_write(REG_DEPTH, d);
        cfg_write(REG_WIDTH, w);
      end
    endcase
  endtask

  // request driver
  int send_gap;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (send_gap > 0) begin
        in_ch.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (req_q.size() != 0) begin
        in_ch.valid <= 1'b1;
        in_ch.kind <= req_q[0].kind;
        in_ch.in_x <= req_q[0].vx;
        in_ch.in_y <= req_q[0].vy;
        in_ch.in_z <= req_q[0].vz;
        in_ch.in_mask <= req_q[0].mask;
        void'(req_q.pop_front());
        if (calm_phase) send_gap <= 0;
        else if ($urandom_range(0, 49) == 0) send_gap <= $urandom_range(10, 40);
        else if ($urandom_range(0, 2) == 0) send_gap <= $urandom_range(1, 3);
        else send_gap <= 0;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result ready with random gaps and long hold-offs on request
  int recv_gap;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_gap <= 0;
      stall_done_cnt <= 0;
    end else if (stall_done_cnt != stall_req_cnt) begin
      out_ch.ready <= 1'b0;
      recv_gap <= $urandom_range(250, 300);
      stall_done_cnt <= stall_req_cnt;
    end else if (recv_gap > 0) begin
      out_ch.ready <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (calm_phase) recv_gap <= 0;
      else if ($urandom_range(0, 59) == 0) recv_gap <= $urandom_range(10, 40);
      else if ($urandom_range(0, 3) == 0) recv_gap <= $urandom_range(1, 3);
      else recv_gap <= 0;
    end
  end

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    err_cnt++;
  endtask

  // result monitor
  always @(posedge clk) begin
    flip_res_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (flip_q.size() == 0) begin
        report_mismatch("result with nothing pending", out_ch.out_x, 16'h0000);
      end else begin
        w = flip_q.pop_front();
        if (out_ch.out_x !== w.vx) report_mismatch("out_x", out_ch.out_x, w.vx);
        if (out_ch.out_y !== w.vy) report_mismatch("out_y", out_ch.out_y, w.vy);
        if (out_ch.out_z !== w.vz) report_mismatch("out_z", out_ch.out_z, w.vz);
        if (out_ch.out_flipped !== w.flipped)
          report_mismatch("out_flipped", 16'(out_ch.out_flipped), 16'(w.flipped));
        if (out_ch.out_last !== w.last)
          report_mismatch("out_last", 16'(out_ch.out_last), 16'(w.last));
      end
    end
  end

  // watchdog on cycles without any handshake
  int idle_cnt;
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // stimulus sequence
  initial begin
    int sent;
    logic [15:0] ext [4];
    err_cnt = 0;
    calm_phase = 1'b0;
    stall_req_cnt = 0;
    rx_pos = 0;
    tx_pos = 0;
    geo_w_reg = 256;
    geo_h_reg = 256;
    geo_d_reg = 1;
    ext[0] = 16'h7fff;
    ext[1] = 16'h8000;
    ext[2] = 16'h0000;
    ext[3] = 16'hffff;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed 2x2x2 cube: extremes, saturating negation, zero product
    set_geometry(16'd2, 16'd2, 16'd2);
    push_req(KIND_FLUSH, 16'h0, 16'h0, 16'h0, 1'b0);
    push_req(KIND_VOXEL, 16'h8000, 16'h8000, 16'h8000, 1'b1);
    push_req(KIND_VOXEL, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
    push_req(KIND_VOXEL, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    push_req(KIND_VOXEL, 16'hffff, 16'h0001, 16'h0000, 1'b0);
    push_req(KIND_FLUSH, 16'hffff, 16'hffff, 16'hffff, 1'b1);
    push_req(KIND_VOXEL, 16'h7fff, 16'h8000, 16'h0001, 1'b1);
    push_req(KIND_VOXEL, 16'h0001, 16'h0001, 16'h0000, 1'b1);
    push_req(KIND_VOXEL, 16'hffff, 16'h0000, 16'h0001, 1'b1);
    push_req(KIND_VOXEL, 16'h8000, 16'h7fff, 16'hffff, 1'b1);
    push_req(KIND_VOXEL, 16'h1234, 16'h8765, 16'h5555, 1'b1);
    for (int n = 0; n < 4; n++) push_req(KIND_FLUSH, ext[n], ext[n], ext[n], n[0]);
    push_req(KIND_FLUSH, 16'h0, 16'h0, 16'h0, 1'b0);

    // geometry extremes and out-of-range codes
    set_geometry(16'd256, 16'd1, 16'd1);
    void'(push_volume());
    set_geometry(16'd1, 16'd256, 16'd1);
    void'(push_volume());
    set_geometry(16'd0, 16'd0, 16'd0);
    void'(push_volume());
    void'(push_volume());
    set_geometry(16'hffff, 16'hffff, 16'hffff);
    repeat (200) push_rand_voxel();
    set_geometry(16'd1, 16'd1, 16'hffff);
    repeat (150) push_rand_voxel();

    // random geometries; the first one runs with a long receiver hold-off
    sent = 0;
    while (sent < RAND_VOXELS) begin
      set_geometry(16'($urandom_range(0, 9)), 16'($urandom_range(0, 6)),
                   16'($urandom_range(0, 4)));
      calm_phase = ($urandom_range(0, 4) == 0);
      if (sent == 0) stall_req_cnt++;
      repeat ($urandom_range(1, 3)) sent += push_volume();
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 20)) push_rand_voxel();
    end
    calm_phase = 1'b0;

    wait_idle();
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/vfof_pkg.sv
design/vfof_if.sv
design/vfof_delay.sv
design/vfof_calc.sv
design/vector_field_orientation_flip_top.sv
verif/vector_field_orientation_flip_top_tb.sv
